### rtl/lagint_pkg.sv
// ----------------------------------------------------------------------------
// lagint_pkg
// Shared types, widths and constants of the Lagrange interpolator.
// ----------------------------------------------------------------------------
package lagint_pkg;

  localparam int LI_NODES = 11;   // default node count (2 to 16)
  localparam int CNT_W    = 5;    // node counters, wide enough to hold 16

  localparam int NODE_W   = 18;   // signed q1.16 node value
  localparam int POS_W    = 18;   // unsigned q2.16 position
  localparam int SCL_W    = 22;   // position * 10 + 1
  localparam int T_W      = 20;   // position in node steps, unsigned q.16
  localparam int OPB_W    = 21;   // second multiplier operand
  localparam int WEIGHT_W = 42;   // signed q.24 weight, clipped to +/- 2^40
  localparam int HALF_W   = 21;   // weight split for the shared multiplier
  localparam int PLO_W    = 43;
  localparam int PHI_W    = 42;
  localparam int PROD_W   = 62;   // weight times operand
  localparam int MAG_W    = 61;
  localparam int ACC_W    = 63;
  localparam int DIV_W    = 48;   // dividend and quotient
  localparam int DIV_STEP = 8;    // quotient bits per cycle
  localparam int DEN_W    = 4;    // node distance 1..15

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  // floor(n / 3) = (n * RECIP3) >> 23 for every n below 2^23
  localparam logic [SCL_W-1:0] RECIP3 = 22'd2796203;
  localparam int RECIP3_SH = 23;

  localparam logic signed [WEIGHT_W-1:0] W_ONE = 42'sd16777216;
  localparam logic [DIV_W-1:0]           W_LIM = 48'd1099511627776;

  typedef logic signed [NODE_W-1:0]   node_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_NODE,
    ST_STEP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_ABS,
    ST_RND,
    ST_DIV,
    ST_ACC,
    ST_FIN_ABS,
    ST_FIN_RND
  } lagint_state_t;

  // node values after reset: round(65536 * (1 - exp(-0.3*i)))
  function automatic node_t reset_node(input logic [3:0] idx);
    node_t v;
    unique case (idx)
      4'd0:    v = 18'sd0;
      4'd1:    v = 18'sd16986;
      4'd2:    v = 18'sd29569;
      4'd3:    v = 18'sd38891;
      4'd4:    v = 18'sd45797;
      4'd5:    v = 18'sd50913;
      4'd6:    v = 18'sd54703;
      4'd7:    v = 18'sd57511;
      4'd8:    v = 18'sd59591;
      4'd9:    v = 18'sd61132;
      4'd10:   v = 18'sd62273;
      4'd11:   v = 18'sd63119;
      4'd12:   v = 18'sd63745;
      4'd13:   v = 18'sd64209;
      4'd14:   v = 18'sd64553;
      default: v = 18'sd64808;
    endcase
    return v;
  endfunction

endpackage

### rtl/lagint_node_mem.sv
// ----------------------------------------------------------------------------
// lagint_node_mem
// Node value store: one write port, one registered read port, a valid bit
// per entry so that unwritten entries read back their reset value.
// ----------------------------------------------------------------------------
module lagint_node_mem #(
  parameter int NODES = lagint_pkg::LI_NODES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      we,
  input  logic [$clog2(NODES)-1:0]  waddr,
  input  lagint_pkg::node_t         wdata,
  input  logic [$clog2(NODES)-1:0]  raddr,
  output lagint_pkg::node_t         rdata
);
  import lagint_pkg::*;

  localparam int AW = $clog2(NODES);

  node_t            ram [NODES];
  node_t            ram_q;
  logic [AW-1:0]    raddr_q;
  logic [NODES-1:0] vld;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
    ram_q   <= ram[raddr];
    raddr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      vld_q <= vld[raddr];
    end
  end

  assign rdata = vld_q ? ram_q : reset_node(4'(raddr_q));

endmodule

### rtl/lagint_div.sv
// ----------------------------------------------------------------------------
// lagint_div
// Serial unsigned divider of a wide dividend by a 4-bit divisor, several
// quotient bits per cycle. done pulses once the quotient is ready.
// ----------------------------------------------------------------------------
module lagint_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [lagint_pkg::DIV_W-1:0]   dividend,
  input  logic [lagint_pkg::DEN_W-1:0]   divisor,
  output logic                           done,
  output logic [lagint_pkg::DIV_W-1:0]   quotient
);
  import lagint_pkg::*;

  localparam int CYC   = DIV_W / DIV_STEP;
  localparam int CNT_B = (CYC > 1) ? $clog2(CYC) : 1;
  localparam logic [CNT_B-1:0] LAST = CNT_B'(CYC - 1);

  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] quo_next;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem_next;
  logic [DEN_W-1:0] den;
  logic [CNT_B-1:0] cnt;
  logic             run;

  // restoring division, DIV_STEP bits per cycle
  always_comb begin
    logic [DEN_W:0] r5;
    rem_next = rem;
    quo_next = quo;
    for (int s = 0; s < DIV_STEP; s++) begin
      r5       = {rem_next, quo_next[DIV_W-1]};
      quo_next = {quo_next[DIV_W-2:0], 1'b0};
      if (r5 >= {1'b0, den}) begin
        r5          = r5 - {1'b0, den};
        quo_next[0] = 1'b1;
      end
      rem_next = r5[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (run) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

### rtl/lagrange_interpolator.sv
// ----------------------------------------------------------------------------
// lagrange_interpolator
// Lagrange interpolating polynomial through equally spaced nodes, q1.16.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A write request
// (req_type 0) stores node_value at node_index in that same edge, gives no
// result and leaves busy low; an index at or above NODES is dropped. An
// evaluate request (req_type 1) raises busy and, once done, presents
// interp_value and saturated for exactly one cycle with done high; the
// receiver must take it then. The run time of an evaluation is set by the
// weight steps: each one passes the shared 21x21 multiplier twice and the
// 8-bit-per-cycle divider by the node distance. Node values come from a
// small store that holds the rising exponential reset profile until written.
// ----------------------------------------------------------------------------
module lagrange_interpolator #(
  parameter int NODES = lagint_pkg::LI_NODES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type,
  input  logic [3:0]                node_index,
  input  lagint_pkg::node_t         node_value,
  input  logic [lagint_pkg::POS_W-1:0] x_pos,
  output logic                      done,
  output lagint_pkg::node_t         interp_value,
  output logic                      saturated
);
  import lagint_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam logic [CNT_W-1:0] NODE_LIM  = CNT_W'(NODES);
  localparam logic [CNT_W-1:0] NODE_LAST = CNT_W'(NODES - 1);
  localparam int RND_W = MAG_W + 1;
  localparam int FMAG_W = ACC_W;
  localparam int RES_W = FMAG_W - 24;

  lagint_state_t state;
  lagint_state_t state_next;

  logic [SCL_W-1:0]        scl;
  logic [T_W-1:0]          t;
  logic [CNT_W-1:0]        i;
  logic [CNT_W-1:0]        j;
  logic                    acc_phase;
  weight_t                 w;
  logic signed [PLO_W-1:0] plo;
  logic signed [PHI_W-1:0] phi;
  logic signed [PROD_W-1:0] prod;
  logic [MAG_W-1:0]        mag;
  logic                    neg;
  logic signed [ACC_W-1:0] acc;
  logic [FMAG_W-1:0]       fmag;
  logic                    fneg;
  logic                    flag;

  logic                    accept;
  logic                    mem_we;
  node_t                   nv;
  logic signed [OPB_W-1:0] d;
  logic signed [OPB_W-1:0] opb;
  logic [DEN_W-1:0]        k;
  logic [RND_W-1:0]        rnd_sum;
  logic                    div_start;
  logic                    div_done;
  logic [DIV_W-1:0]        div_quo;
  logic [DIV_W-1:0]        q_clip;
  logic                    q_over;
  logic [FMAG_W-1:0]       fin_sum;
  logic [RES_W-1:0]        res;

  lagint_node_mem #(.NODES(NODES)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (node_index[AW-1:0]),
    .wdata (node_value),
    .raddr (i[AW-1:0]),
    .rdata (nv)
  );

  lagint_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIV_W'(rnd_sum >> 16)),
    .divisor  (k),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign accept = start && !busy;

  // datapath helpers
  assign d   = $signed({1'b0, t}) - $signed({1'b0, j[3:0], 16'h0000});
  assign opb = acc_phase ? OPB_W'(nv) : d;
  assign k   = (i < j) ? DEN_W'(j - i) : DEN_W'(i - j);
  // half-up rounding before the divide by 65536 * distance
  assign rnd_sum = {1'b0, mag} + RND_W'({k, 15'h0000});
  assign q_over  = div_quo > W_LIM;
  assign q_clip  = q_over ? W_LIM : div_quo;
  assign fin_sum = fmag + FMAG_W'(24'h800000);
  assign res     = fin_sum[FMAG_W-1:24];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && req_type == REQ_EVAL) state_next = ST_SCALE;
      end
      ST_SCALE:  state_next = ST_NODE;
      ST_NODE:   state_next = ST_STEP;
      ST_STEP: begin
        if (j == NODE_LIM || j != i) state_next = ST_MUL_LO;
      end
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_SUM;
      ST_SUM:    state_next = acc_phase ? ST_ACC : ST_ABS;
      ST_ABS:    state_next = ST_RND;
      ST_RND:    state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) state_next = ST_STEP;
      end
      ST_ACC:    state_next = (i == NODE_LAST) ? ST_FIN_ABS : ST_NODE;
      ST_FIN_ABS: state_next = ST_FIN_RND;
      ST_FIN_RND: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy      = (state != ST_IDLE);
    div_start = (state == ST_RND);
    mem_we    = (state == ST_IDLE) && start && (req_type == REQ_WRITE)
                && ({1'b0, node_index} < NODE_LIM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FIN_RND);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept && req_type == REQ_EVAL) begin
          scl  <= SCL_W'(x_pos) * SCL_W'(10) + SCL_W'(1);
          i    <= '0;
          acc  <= '0;
          flag <= 1'b0;
        end
      end
      ST_SCALE: begin
        t <= T_W'(((2*SCL_W)'(scl) * (2*SCL_W)'(RECIP3)) >> RECIP3_SH);
      end
      ST_NODE: begin
        w <= W_ONE;
        j <= '0;
      end
      ST_STEP: begin
        if (j == NODE_LIM) begin
          acc_phase <= 1'b1;
        end else if (j == i) begin
          j <= j + 1'b1;
        end else begin
          acc_phase <= 1'b0;
        end
      end
      ST_MUL_LO: plo <= PLO_W'($signed({1'b0, w[HALF_W-1:0]})) * PLO_W'(opb);
      ST_MUL_HI: phi <= PHI_W'($signed(w[WEIGHT_W-1:HALF_W])) * PHI_W'(opb);
      ST_SUM:    prod <= (PROD_W'(phi) <<< HALF_W) + PROD_W'(plo);
      ST_ABS: begin
        mag <= MAG_W'(prod[PROD_W-1] ? -prod : prod);
        neg <= prod[PROD_W-1] ^ (i < j);
      end
      ST_RND: begin
      end
      ST_DIV: begin
        if (div_done) begin
          // weight clipped to +/- 2^40, the evaluation goes on with it
          w <= neg ? -WEIGHT_W'(q_clip) : WEIGHT_W'(q_clip);
          if (q_over) flag <= 1'b1;
          j <= j + 1'b1;
        end
      end
      ST_ACC: begin
        acc <= acc + ACC_W'(prod);
        i   <= i + 1'b1;
      end
      ST_FIN_ABS: begin
        fmag <= FMAG_W'(acc[ACC_W-1] ? -acc : acc);
        fneg <= acc[ACC_W-1];
      end
      ST_FIN_RND: begin
        if (fneg) begin
          if (res > RES_W'(131072)) begin
            interp_value <= -18'sd131072;
            saturated    <= 1'b1;
          end else begin
            interp_value <= -$signed(NODE_W'(res));
            saturated    <= flag;
          end
        end else begin
          if (res > RES_W'(131071)) begin
            interp_value <= 18'sd131071;
            saturated    <= 1'b1;
          end else begin
            interp_value <= $signed(NODE_W'(res));
            saturated    <= flag;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
